// File: hw/rtl/deq_pkg.sv
// Shared types for the double-ended queue: command and status codes,
// the input and result beat structs, and default sizing constants.
// No dependencies.
package deq_pkg;

  localparam int unsigned DEQ_DEPTH   = 8;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned OCC_W       = 4;

  // Command codes
  typedef enum logic [1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_REAR  = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_REAR   = 2'd3
  } deq_cmd_t;

  // Status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } deq_status_t;

  // Input beat
  typedef struct packed {
    deq_cmd_t           cmd;
    logic signed [31:0] value;
  } deq_in_t;

  // Result beat
  typedef struct packed {
    deq_status_t        status;
    logic signed [31:0] removed_value;
    logic [3:0]         occupancy;
  } deq_out_t;

  // Per-command result from the control unit, before the slot read returns
  typedef struct packed {
    deq_status_t status;
    logic        take;       // removal: result word comes from slot read
    logic [3:0]  occupancy;
  } deq_res_t;

endpackage

// File: hw/rtl/deq_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module deq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write, or read into the output register; rdata holds between reads
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/deq_ctrl.sv
// Index control for the double-ended queue: head/tail/empty state,
// per-command decision, slot access request and result fields.
// Depends on deq_pkg.
module deq_ctrl import deq_pkg::*; #(
  parameter int unsigned DEPTH = DEQ_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     acc,
  input  deq_in_t                  item,
  output logic                     mem_en,
  output logic                     mem_we,
  output logic [$clog2(DEPTH)-1:0] mem_addr,
  output deq_res_t                 res
);

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CW   = (AW + 1 > OCC_W) ? AW + 1 : OCC_W;
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic          empty_r, empty_nxt;
  logic          req_en;
  logic          req_we;
  logic [CW-1:0] span;

  // Command decode against current indices
  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    empty_nxt  = empty_r;
    req_en     = 1'b0;
    req_we     = 1'b0;
    mem_addr   = head_r;
    res.status = ST_OK;
    res.take   = 1'b0;
    case (item.cmd)
      CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
        if (empty_r) begin
          // first element always lands in slot 0
          head_nxt  = '0;
          tail_nxt  = '0;
          empty_nxt = 1'b0;
          req_en    = 1'b1;
          req_we    = 1'b1;
          mem_addr  = '0;
        end else if (item.cmd == CMD_PUSH_FRONT) begin
          if (head_r == '0) begin
            res.status = ST_FULL;
          end else begin
            head_nxt = head_r - AW'(1);
            req_en   = 1'b1;
            req_we   = 1'b1;
            mem_addr = head_nxt;
          end
        end else begin
          if (tail_r == LAST) begin
            res.status = ST_FULL;
          end else begin
            tail_nxt = tail_r + AW'(1);
            req_en   = 1'b1;
            req_we   = 1'b1;
            mem_addr = tail_nxt;
          end
        end
      end
      CMD_POP_FRONT, CMD_POP_REAR: begin
        if (empty_r) begin
          res.status = ST_EMPTY;
        end else begin
          req_en   = 1'b1;
          res.take = 1'b1;
          mem_addr = (item.cmd == CMD_POP_FRONT) ? head_r : tail_r;
          if (head_r == tail_r) begin
            // last element gone: back to initial position
            head_nxt  = '0;
            tail_nxt  = '0;
            empty_nxt = 1'b1;
          end else if (item.cmd == CMD_POP_FRONT) begin
            head_nxt = head_r + AW'(1);
          end else begin
            tail_nxt = tail_r - AW'(1);
          end
        end
      end
      default: begin
        res.status = ST_OK;
      end
    endcase

    // Occupancy after the command, reported modulo 16
    span          = CW'(tail_nxt) - CW'(head_nxt) + CW'(1);
    res.occupancy = empty_nxt ? '0 : span[OCC_W-1:0];
  end

  assign mem_en = acc & req_en;
  assign mem_we = req_we;

  // Index state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      empty_r <= 1'b1;
    end else if (acc) begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      empty_r <= empty_nxt;
    end
  end

endmodule

// File: hw/rtl/double_ended_queue.sv
// Double-ended queue on a linear, non-wrapping slot array: top level.
// Depends on deq_pkg, deq_ctrl and deq_ram.
//
// Each input beat is one command (push front, push rear, pop front, pop rear)
// and yields exactly one result beat with status, removed word and occupancy.
// A command is accepted every cycle whenever the result register is free or
// being drained; its result appears in the cycle after acceptance, with the
// removed word read through the registered slot RAM port. Indices never
// wrap: push front fails at slot 0 and push rear fails at slot DEPTH-1 even
// if the other side has room. Emptying the queue returns both indices to
// slot 0. Slots are not cleared at reset; only written slots are ever read.
module double_ended_queue import deq_pkg::*; #(
  parameter int unsigned DEPTH = DEQ_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  deq_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output deq_out_t out_data
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic              acc;
  logic              mem_en;
  logic              mem_we;
  logic [AW-1:0]     mem_addr;
  logic [DATA_W-1:0] mem_rdata;
  deq_res_t          res;
  deq_res_t          res_r;
  logic              out_valid_r, out_valid_nxt;

  // Beat accepted when the result register is empty or draining
  assign in_stall = out_valid_r & out_stall;
  assign acc      = in_valid & ~in_stall;

  deq_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .item     (in_data),
    .mem_en   (mem_en),
    .mem_we   (mem_we),
    .mem_addr (mem_addr),
    .res      (res)
  );

  deq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (in_data.value),
    .rdata (mem_rdata)
  );

  // Result register; read data holds while stalled since no new read issues
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (acc) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      res_r <= res;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_data.status        = res_r.status;
  assign out_data.removed_value = res_r.take ? mem_rdata : '0;
  assign out_data.occupancy     = res_r.occupancy;

endmodule
